### src/nfpa_pkg.sv
`timescale 1ns / 1ps
package nfpa_pkg;
  localparam int unsigned DEF_HEAP_PAGES  = 1024;
  localparam int unsigned DEF_PAGE_SHIFT  = 12;
  localparam int unsigned DEF_TABLE_SLOTS = 256;

  localparam logic [31:0] HEAP_BASE_RST = 32'h8000_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RUN    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;
endpackage

### src/nfpa_if.sv
`timescale 1ns / 1ps
interface nfpa_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] request_bytes;
  logic [31:0] release_address;

  modport source (output valid, opcode, request_bytes, release_address, input ready);
  modport sink (input valid, opcode, request_bytes, release_address, output ready);
endinterface

interface nfpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] run_address;
  logic [10:0] run_pages;

  modport source (output valid, status, run_address, run_pages, input ready);
  modport sink (input valid, status, run_address, run_pages, output ready);
endinterface

### src/nfpa_ram.sv
`timescale 1ns / 1ps
module nfpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/next_fit_page_allocator.sv
`timescale 1ns / 1ps
// allocate scans the table ram for a free slot, then the bitmap ram from the next-fit pointer for a
// free run, then marks it; free scans the table for the address, then clears the run's pages
// throughput: one transaction at a time, the next is taken once the result has been taken
// reset: synchronous, active low; then a clearing pass wipes bitmap and table while no
// transaction is taken
module next_fit_page_allocator #(
  parameter int unsigned HEAP_PAGES  = nfpa_pkg::DEF_HEAP_PAGES,
  parameter int unsigned PAGE_SHIFT  = nfpa_pkg::DEF_PAGE_SHIFT,
  parameter int unsigned TABLE_SLOTS = nfpa_pkg::DEF_TABLE_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  nfpa_req_if.sink    in_chan,
  nfpa_rsp_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import nfpa_pkg::*;

  // page index, page count and slot widths
  localparam int unsigned AW  = $clog2(HEAP_PAGES);
  localparam int unsigned PW  = $clog2(HEAP_PAGES + 1);
  localparam int unsigned SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned TWD = 1 + AW + PW;
  localparam int unsigned CLR_MAX = (HEAP_PAGES > TABLE_SLOTS) ? HEAP_PAGES : TABLE_SLOTS;
  localparam int unsigned CW  = $clog2(CLR_MAX + 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_TRD, S_TCHK, S_BRD, S_BCHK, S_MARK, S_OUT
  } state_t;

  state_t          state_r;
  logic [31:0]     heap_base_r;
  logic [CW-1:0]   clr_r;
  logic            op_r;
  logic [31:0]     rel_r;
  logic [PW-1:0]   need_r;
  logic [SW-1:0]   idx_r;
  logic [SW-1:0]   slot_r;
  logic [PW-1:0]   nf_r;
  logic [PW-1:0]   old_r;
  logic            pass_r;
  logic [PW-1:0]   pg_r;
  logic [PW-1:0]   end_r;
  logic [PW-1:0]   cnt_r;
  logic [PW-1:0]   start_r;
  logic [2:0]      st_r;
  logic [31:0]     addr_r;
  logic [10:0]     pages_r;

  // bitmap and run table ports
  logic            b_we;
  logic [AW-1:0]   b_waddr;
  logic [0:0]      b_wdata;
  logic [AW-1:0]   b_raddr;
  logic [0:0]      b_rdata;
  logic            t_we;
  logic [SW-1:0]   t_waddr;
  logic [TWD-1:0]  t_wdata;
  logic [SW-1:0]   t_raddr;
  logic [TWD-1:0]  t_rdata;

  nfpa_ram #(.WIDTH(1), .DEPTH(HEAP_PAGES)) u_bitmap (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata)
  );

  nfpa_ram #(.WIDTH(TWD), .DEPTH(TABLE_SLOTS)) u_table (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  // table entry fields
  logic          t_valid;
  logic [AW-1:0] t_start;
  logic [PW-1:0] t_pages;
  assign t_valid = t_rdata[TWD-1];
  assign t_start = t_rdata[PW +: AW];
  assign t_pages = t_rdata[PW-1:0];

  logic [31:0] t_addr;
  assign t_addr = heap_base_r + (32'(t_start) << PAGE_SHIFT);

  // round byte size up to pages
  logic [32:0] need_w;
  assign need_w = ({1'b0, in_chan.request_bytes} + 33'((64'd1 << PAGE_SHIFT) - 64'd1))
                  >> PAGE_SHIFT;

  logic [PW-1:0] cnt_nxt;
  assign cnt_nxt = b_rdata[0] ? '0 : cnt_r + PW'(1);

  logic mark_done;
  assign mark_done = (pg_r >= end_r);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = (state_r == S_OUT);
  assign out_chan.status      = st_r;
  assign out_chan.run_address = addr_r;
  assign out_chan.run_pages   = pages_r;

  always_comb begin
    b_we    = 1'b0;
    b_waddr = pg_r[AW-1:0];
    b_wdata = (op_r == OP_ALLOC) ? 1'b1 : 1'b0;
    b_raddr = pg_r[AW-1:0];
    t_we    = 1'b0;
    t_waddr = slot_r;
    t_wdata = {(op_r == OP_ALLOC), start_r[AW-1:0], need_r};
    t_raddr = idx_r;
    case (state_r)
      S_CLR: begin
        b_waddr = clr_r[AW-1:0];
        b_wdata = 1'b0;
        b_we    = (clr_r < CW'(HEAP_PAGES));
        t_waddr = clr_r[SW-1:0];
        t_wdata = '0;
        t_we    = (clr_r < CW'(TABLE_SLOTS));
      end
      S_MARK: begin
        b_we = !mark_done;
        t_we = mark_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      heap_base_r <= HEAP_BASE_RST;
      clr_r       <= '0;
      nf_r        <= '0;
    end else begin
      if (cfg_we) begin
        heap_base_r <= cfg_wdata;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r == CW'(CLR_MAX - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r   <= in_chan.opcode;
            rel_r  <= in_chan.release_address;
            need_r <= PW'(need_w);
            idx_r  <= '0;
            st_r   <= ST_OK;
            addr_r <= '0;
            pages_r <= '0;
            state_r <= S_TRD;
            if (in_chan.opcode == OP_ALLOC) begin
              if (in_chan.request_bytes == 32'd0) begin
                st_r    <= ST_ZERO;
                state_r <= S_OUT;
              end else if (need_w > 33'(HEAP_PAGES)) begin
                st_r    <= ST_NO_RUN;
                state_r <= S_OUT;
              end
            end
          end
        end
        S_TRD: state_r <= S_TCHK;
        S_TCHK: begin
          if (op_r == OP_ALLOC) begin
            if (!t_valid) begin
              // free slot found, start next-fit scan from the pointer
              slot_r  <= idx_r;
              old_r   <= nf_r;
              pg_r    <= nf_r;
              end_r   <= PW'(HEAP_PAGES);
              pass_r  <= 1'b0;
              cnt_r   <= '0;
              state_r <= S_BRD;
            end else if (idx_r == SW'(TABLE_SLOTS - 1)) begin
              st_r    <= ST_FULL;
              state_r <= S_OUT;
            end else begin
              idx_r   <= idx_r + SW'(1);
              state_r <= S_TRD;
            end
          end else begin
            if (t_valid && (t_addr == rel_r)) begin
              slot_r  <= idx_r;
              start_r <= PW'(t_start);
              pg_r    <= PW'(t_start);
              end_r   <= PW'(t_start) + t_pages;
              addr_r  <= rel_r;
              pages_r <= 11'(t_pages);
              state_r <= S_MARK;
            end else if (idx_r == SW'(TABLE_SLOTS - 1)) begin
              st_r    <= ST_NOT_FOUND;
              state_r <= S_OUT;
            end else begin
              idx_r   <= idx_r + SW'(1);
              state_r <= S_TRD;
            end
          end
        end
        S_BRD: begin
          if (pg_r >= end_r) begin
            if (!pass_r) begin
              // wrap to heap start, runs across the wrap are not joined
              pass_r <= 1'b1;
              pg_r   <= '0;
              end_r  <= old_r;
              cnt_r  <= '0;
            end else begin
              st_r    <= ST_NO_RUN;
              state_r <= S_OUT;
            end
          end else begin
            state_r <= S_BCHK;
          end
        end
        S_BCHK: begin
          cnt_r <= cnt_nxt;
          if (cnt_nxt == need_r) begin
            start_r <= pg_r + PW'(1) - need_r;
            pg_r    <= pg_r + PW'(1) - need_r;
            end_r   <= pg_r + PW'(1);
            state_r <= S_MARK;
          end else begin
            pg_r    <= pg_r + PW'(1);
            state_r <= S_BRD;
          end
        end
        S_MARK: begin
          if (!mark_done) begin
            pg_r <= pg_r + PW'(1);
          end else begin
            // table entry written this cycle
            if (op_r == OP_ALLOC) begin
              nf_r    <= end_r;
              addr_r  <= heap_base_r + (32'(start_r) << PAGE_SHIFT);
              pages_r <= 11'(need_r);
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_chan.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/nfpa_checker.sv
`timescale 1ns / 1ps
module nfpa_checker (
  input  logic        clk,
  input  logic        rst_n,
  nfpa_req_if         in_mon,
  nfpa_rsp_if         out_mon,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int unsigned fail_count,
  output int unsigned pending
);
  import nfpa_pkg::*;

  localparam int unsigned HEAP_PAGES  = DEF_HEAP_PAGES;
  localparam int unsigned PAGE_SHIFT  = DEF_PAGE_SHIFT;
  localparam int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] run_address;
    logic [10:0] run_pages;
  } page_result_t;

  page_result_t expected_runs[$];

  logic [31:0] heap_base;
  bit          page_used[HEAP_PAGES];
  int unsigned next_fit;
  bit          slot_valid[TABLE_SLOTS];
  int unsigned slot_start[TABLE_SLOTS];
  int unsigned slot_pages[TABLE_SLOTS];

  function automatic logic [31:0] page_to_addr(int unsigned page);
    return heap_base + 32'(page << PAGE_SHIFT);
  endfunction

  function automatic bit find_run(int unsigned lo, int unsigned hi, int unsigned need,
                                  output int unsigned start);
    int unsigned run_len;
    run_len = 0;
    start = 0;
    for (int unsigned p = lo; p < hi && p < HEAP_PAGES; p++) begin
      run_len = page_used[p] ? 0 : run_len + 1;
      if (run_len == need) begin
        start = p + 1 - need;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic page_result_t serve(logic op, logic [31:0] bytes, logic [31:0] addr);
    logic [32:0] need;
    int          slot;
    int unsigned start;
    int unsigned old_ptr;
    bit          found;
    slot = -1;
    if (op == OP_ALLOC) begin
      if (bytes == 0) return '{ST_ZERO, 32'd0, 11'd0};
      need = ({1'b0, bytes} + ((33'd1 << PAGE_SHIFT) - 33'd1)) >> PAGE_SHIFT;
      if (need > HEAP_PAGES) return '{ST_NO_RUN, 32'd0, 11'd0};
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (!slot_valid[i] && slot < 0) slot = i;
      if (slot < 0) return '{ST_FULL, 32'd0, 11'd0};
      old_ptr = (next_fit > HEAP_PAGES) ? HEAP_PAGES : next_fit;
      found = find_run(old_ptr, HEAP_PAGES, need, start);
      if (!found) found = find_run(0, old_ptr, need, start);
      if (!found) return '{ST_NO_RUN, 32'd0, 11'd0};
      for (int unsigned p = start; p < start + need && p < HEAP_PAGES; p++) page_used[p] = 1'b1;
      next_fit = start + need;
      slot_valid[slot] = 1'b1;
      slot_start[slot] = start;
      slot_pages[slot] = need;
      return '{ST_OK, page_to_addr(start), 11'(need)};
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_valid[i] && page_to_addr(slot_start[i]) == addr) begin
        for (int unsigned p = slot_start[i]; p < slot_start[i] + slot_pages[i] && p < HEAP_PAGES;
             p++)
          page_used[p] = 1'b0;
        slot_valid[i] = 1'b0;
        return '{ST_OK, addr, 11'(slot_pages[i])};
      end
    end
    return '{ST_NOT_FOUND, 32'd0, 11'd0};
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    if (!rst_n) begin
      heap_base = HEAP_BASE_RST;
      next_fit = 0;
      foreach (page_used[p]) page_used[p] = 1'b0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      expected_runs.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) heap_base = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_runs.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction at %0t", $realtime);
          fail_count++;
        end else begin
          want = expected_runs.pop_front();
          if (out_mon.status !== want.status || out_mon.run_address !== want.run_address ||
              out_mon.run_pages !== want.run_pages) begin
            if (fail_count < 10)
              $display("mismatch at %0t: status %0d/%0d address %h/%h pages %0d/%0d (exp/act)",
                       $realtime, want.status, out_mon.status, want.run_address,
                       out_mon.run_address, want.run_pages, out_mon.run_pages);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_runs.push_back(serve(in_mon.opcode, in_mon.request_bytes,
                                      in_mon.release_address));
    end
    pending = expected_runs.size();
  end
endmodule

### tb/next_fit_page_allocator_test.sv
`timescale 1ns / 1ps
module next_fit_page_allocator_test;
  import nfpa_pkg::*;

  // no-progress limit, set above the worst allocate, the clearing pass after reset and the
  // long receiver hold
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PAGE_BYTES  = 1 << DEF_PAGE_SHIFT;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int unsigned fail_count;
  int unsigned pending;

  nfpa_req_if req_chan();
  nfpa_rsp_if rsp_chan();

  next_fit_page_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_chan),
    .out_chan  (rsp_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nfpa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (req_chan),
    .out_mon    (rsp_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus shaping state
  logic [31:0] cur_base;
  bit          idle_on;
  bit          hold_request;
  logic        op_log[$];
  logic [31:0] live_offsets[$];
  int unsigned quiet_cycles = 0;

  // keep track of which runs are live, as offsets from the base, so frees can hit them
  always @(posedge clk) begin
    logic op;
    if (rst_n) begin
      if (req_chan.valid && req_chan.ready) op_log.push_back(req_chan.opcode);
      if (rsp_chan.valid && rsp_chan.ready && op_log.size() > 0) begin
        op = op_log.pop_front();
        if (op == OP_ALLOC && rsp_chan.status == ST_OK)
          live_offsets.push_back(rsp_chan.run_address - cur_base);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall per transaction, one long hold when asked
  initial begin
    int unsigned stall;
    bit          hold_taken;
    hold_taken = 1'b0;
    rsp_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (hold_request && !hold_taken) begin
        // long hold while the sender keeps offering, so the block backs up
        hold_taken = 1'b1;
        rsp_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (stall > 0) begin
        rsp_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_chan.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_chan.valid) @(posedge clk);
    end
  end

  // one request transaction, with a random gap in front
  task automatic send_item(logic op, logic [31:0] bytes, logic [31:0] addr);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid           <= 1'b1;
    req_chan.opcode          <= op;
    req_chan.request_bytes   <= bytes;
    req_chan.release_address <= addr;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  task automatic alloc_bytes(logic [31:0] bytes);
    send_item(OP_ALLOC, bytes, $urandom());
  endtask

  task automatic free_addr(logic [31:0] addr);
    send_item(OP_FREE, $urandom(), addr);
  endtask

  // free a live run picked at random, or a random address if none is live
  task automatic free_some_run();
    int unsigned idx;
    logic [31:0] off;
    if (live_offsets.size() == 0) begin
      free_addr($urandom());
    end else begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      off = live_offsets[idx];
      live_offsets.delete(idx);
      free_addr(cur_base + off);
    end
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) alloc_bytes($urandom_range(1, 16 * PAGE_BYTES));
    else if (pick < 53) alloc_bytes($urandom_range(1, 300 * PAGE_BYTES));
    else if (pick < 57) alloc_bytes($urandom());
    else if (pick < 60) alloc_bytes(32'd0);
    else if (pick < 90) free_some_run();
    else if (pick < 95) free_addr(cur_base + $urandom_range(1, PAGE_BYTES - 1));
    else free_addr($urandom());
  endtask

  // drop valid and wait for every expected result, then let the block settle
  task automatic wait_idle();
    req_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || op_log.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(logic [31:0] base);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    cur_base = base;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // every result in first, so that no live run is missed
  task automatic free_all_live();
    wait_idle();
    while (live_offsets.size() > 0) free_some_run();
    wait_idle();
  endtask

  initial begin
    req_chan.valid           = 1'b0;
    req_chan.opcode          = OP_ALLOC;
    req_chan.request_bytes   = '0;
    req_chan.release_address = '0;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    cur_base                 = HEAP_BASE_RST;
    idle_on                  = 1'b1;
    hold_request             = 1'b0;
    rst_n                    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset base
    alloc_bytes(32'd0);                          // zero size
    alloc_bytes(32'hFFFF_FFFF);                  // oversized, all bits set
    alloc_bytes(1024 * PAGE_BYTES + 1);          // one byte over the heap
    free_addr(HEAP_BASE_RST);                    // nothing allocated yet
    alloc_bytes(1024 * PAGE_BYTES);              // whole heap, pointer goes to heap end
    alloc_bytes(32'd1);                          // heap full
    free_addr(HEAP_BASE_RST);                    // frees the widest run
    free_addr(HEAP_BASE_RST);                    // already freed
    alloc_bytes(32'd1);                          // pointer at heap end, wraps to page 0
    alloc_bytes(PAGE_BYTES);
    alloc_bytes(PAGE_BYTES + 1);                 // rounds up to two pages
    alloc_bytes(32'h8000_0000);
    free_addr(HEAP_BASE_RST + PAGE_BYTES);       // hole at page 1
    alloc_bytes(32'd1);                          // next fit skips the hole
    free_addr(HEAP_BASE_RST + PAGE_BYTES + 1);   // unaligned miss
    alloc_bytes(1020 * PAGE_BYTES);              // free pages split by the wrap point
    alloc_bytes(1019 * PAGE_BYTES);              // exactly fills up to heap end
    alloc_bytes(32'd2);                          // wraps into the page 1 hole
    free_all_live();

    // random mix near the top of the address space, with one long receiver hold
    set_base(32'hFFFF_F000);
    for (int n = 0; n < 8; n++) begin
      if (n == 3) hold_request = 1'b1;
      random_item();
    end

    // base zero, back-to-back with no idling
    set_base(32'h0000_0000);
    idle_on = 1'b0;
    for (int n = 0; n < 6; n++) random_item();
    idle_on = 1'b1;
    free_all_live();

    // fill the run table with single pages, unaligned base
    set_base(32'hFFFF_FFFF);
    for (int n = 0; n < 257; n++) alloc_bytes($urandom_range(1, PAGE_BYTES));
    for (int n = 0; n < 2; n++) free_some_run();
    for (int n = 0; n < 2; n++) alloc_bytes($urandom_range(1, 2 * PAGE_BYTES));
    wait_idle();
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### files.f
src/nfpa_pkg.sv
src/nfpa_if.sv
src/nfpa_ram.sv
src/next_fit_page_allocator.sv
tb/nfpa_checker.sv
tb/next_fit_page_allocator_test.sv
